@@ hdl/orq_pkg.sv @@
`timescale 1ns / 1ps
package orq_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int BYTE_W    = 8;
  localparam int AMT_W     = 9;
  localparam int LVL_W     = 9;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef struct packed {
    logic data_valid;
    logic overwrote;
  } res_flags_t;

endpackage

@@ hdl/orq_mem.sv @@
`timescale 1ns / 1ps
module orq_mem #(
  parameter int DEPTH = orq_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [PW-1:0]             waddr,
  input  logic [orq_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [PW-1:0]             raddr,
  output logic [orq_pkg::BYTE_W-1:0] rdata
);
  import orq_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/orq_ctrl.sv @@
`timescale 1ns / 1ps
module orq_ctrl #(
  parameter int DEPTH = orq_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [orq_pkg::OP_W-1:0]   in_operation,
  input  logic [orq_pkg::AMT_W-1:0]  in_amount,
  output logic                       out_valid,
  input  logic                       out_stall,
  output orq_pkg::res_flags_t        res_flags,
  output logic [orq_pkg::LVL_W-1:0]  fill_level,
  output logic                       mem_we,
  output logic [PW-1:0]              mem_waddr,
  output logic                       mem_re,
  output logic [PW-1:0]              mem_raddr
);
  import orq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > AMT_W) ? CW : AMT_W;
  localparam int SW = ((PW > AMT_W) ? PW : AMT_W) + 1;
  localparam int LW = (CW > LVL_W) ? CW : LVL_W;

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_flags_t    flags_r, flags_nxt;

  logic          fire;
  op_t           op;
  logic [WW-1:0] amt_w, cnt_w;
  logic          amt_lt;
  logic          full, empty;
  logic [SW-1:0] sum;
  logic [PW-1:0] head_add;
  logic [PW-1:0] head_inc, tail_inc;
  logic [LW-1:0] lvl_w;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;
  assign op       = op_t'(in_operation);

  assign amt_w  = WW'(in_amount);
  assign cnt_w  = WW'(cnt_r);
  assign amt_lt = amt_w < cnt_w;
  assign full   = cnt_r == CW'(DEPTH);
  assign empty  = cnt_r == '0;

  assign sum      = SW'(head_r) + SW'(in_amount);
  assign head_add = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
  assign tail_inc = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + PW'(1);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = tail_r;
    mem_raddr     = head_r;
    if (fire) begin
      out_valid_nxt        = 1'b1;
      flags_nxt.data_valid = 1'b0;
      flags_nxt.overwrote  = 1'b0;
      case (op)
        OP_PUSH: begin
          mem_we   = 1'b1;
          tail_nxt = tail_inc;
          if (full) begin
            head_nxt            = tail_inc;
            flags_nxt.overwrote = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_POP: begin
          if (!empty) begin
            mem_re               = 1'b1;
            flags_nxt.data_valid = 1'b1;
            head_nxt             = head_inc;
            cnt_nxt              = cnt_r - CW'(1);
          end
        end
        OP_PEEK: begin
          mem_raddr = head_add;
          if (amt_lt) begin
            mem_re               = 1'b1;
            flags_nxt.data_valid = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (amt_lt) begin
            head_nxt = head_add;
            cnt_nxt  = cnt_r - CW'(in_amount);
          end else begin
            head_nxt = tail_r;
            cnt_nxt  = '0;
          end
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

  assign lvl_w      = LW'(cnt_r);
  assign fill_level = lvl_w[LVL_W-1:0];
  assign out_valid  = out_valid_r;
  assign res_flags  = flags_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("held count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> head_r == tail_r)
    else $error("empty queue with head and tail apart");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op == OP_PUSH && full) |=> full && flags_r.overwrote && head_r == tail_r)
    else $error("overwrite push lost full state");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op == OP_POP && empty) |=> empty && !flags_r.data_valid)
    else $error("pop on empty queue changed state");
`endif

endmodule

@@ hdl/overwriting_byte_ring_queue_unit.sv @@
`timescale 1ns / 1ps
// A result is valid in the cycle after its input transfer.
// Throughput: one operation per cycle while no valid result is stalled;
// the single-port-read ring memory takes at most one write or one read per
// operation, and the result register frees once its transfer completes.
// Reset clears head, tail, fill count and the result valid flag; the byte
// store is not cleared and needs no clearing pass.
module overwriting_byte_ring_queue_unit #(
  parameter int DEPTH = orq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [orq_pkg::OP_W-1:0]    in_operation,
  input  logic [orq_pkg::BYTE_W-1:0]  in_data_in,
  input  logic [orq_pkg::AMT_W-1:0]   in_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [orq_pkg::BYTE_W-1:0]  out_data_out,
  output logic                        out_data_valid,
  output logic                        out_overwrote,
  output logic [orq_pkg::LVL_W-1:0]   out_fill_level
);
  import orq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  res_flags_t        flags;
  logic              mem_we, mem_re;
  logic [PW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  orq_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_amount    (in_amount),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res_flags    (flags),
    .fill_level   (out_fill_level),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr)
  );

  orq_mem #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data_in),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_data_out   = flags.data_valid ? mem_rdata : '0;
  assign out_data_valid = flags.data_valid;
  assign out_overwrote  = flags.overwrote;

endmodule
